[hw/rtl/ebwa_pkg.sv]
// shared constants and types for the event burst window alarm
package ebwa_pkg;

  localparam int MAX_EVENTS_DEFAULT = 16;
  localparam int TIME_BITS_DEFAULT  = 48;

  localparam int COUNT_W    = 5;
  localparam int CFG_ADDR_W = 2;

  localparam logic [COUNT_W-1:0] EVENT_COUNT_RESET    = 5'd8;
  localparam logic [63:0]        TIME_THRESHOLD_RESET = 64'd300000000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EVENT_COUNT    = 2'd0,
    REG_TIME_THRESHOLD = 2'd1
  } cfg_reg_t;

endpackage

[hw/rtl/ebwa_event_if.sv]
// event request channel: valid, ready and the event timestamp
interface ebwa_event_if #(
  parameter int TIME_BITS = ebwa_pkg::TIME_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

[hw/rtl/ebwa_alarm_if.sv]
// result channel: valid, ready, alarm flag and oldest timestamp
interface ebwa_alarm_if #(
  parameter int TIME_BITS = ebwa_pkg::TIME_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic                 alarm;
  logic [TIME_BITS-1:0] oldest_time;

  modport source (output valid, output alarm, output oldest_time, input ready);
  modport sink   (input valid, input alarm, input oldest_time, output ready);
endinterface

[hw/rtl/ebwa_ram.sv]
// generic single write port ram with registered read
module ebwa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/event_burst_window_alarm_top.sv]
// top level of the sliding window event rate alarm
//
// channel   dir  kind             payload
// events    in   valid/ready      event_time
// alarms    out  valid/ready      alarm, oldest_time
// cfg       in   write only       cfg_write, cfg_index, cfg_data
//
// accepts one event per cycle while the result channel is not stalled; a result passes
// through the ring read register, then the result register
// the per-cycle limit is the single ring read port plus the holdoff register loop
// synchronous reset clears control state and the ring valid bits, no clearing pass
// a stalled result holds the pipeline; events.ready drops only when both stages are full
module event_burst_window_alarm_top #(
  parameter int MAX_EVENTS = ebwa_pkg::MAX_EVENTS_DEFAULT,
  parameter int TIME_BITS  = ebwa_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  ebwa_event_if.sink                      events,
  ebwa_alarm_if.source                    alarms,
  input  logic                            cfg_write,
  input  logic [ebwa_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [TIME_BITS-1:0]            cfg_data
);

  localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EVENTS + 1);

  logic [ebwa_pkg::COUNT_W-1:0] event_count;
  logic [TIME_BITS-1:0]         time_threshold;
  logic [TIME_BITS-1:0]         last_alarm_time;
  logic [IDX_W-1:0]             write_index;
  logic [MAX_EVENTS-1:0]        ring_vld;

  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_now;
  logic                 s1_en;
  logic                 s1_same;
  logic                 s1_vld;
  logic [TIME_BITS-1:0] ring_rdata;

  logic                 out_valid;
  logic                 out_alarm;
  logic [TIME_BITS-1:0] out_oldest;

  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] count_new_eff;
  logic [IDX_W-1:0] idx;
  logic [IDX_W:0]   idx_inc;
  logic [IDX_W-1:0] nxt;
  logic             enabled;
  logic             out_free;
  logic             in_ready;
  logic             accept;
  logic             s1_move;
  logic             count_change;

  logic [TIME_BITS-1:0] oldest;
  logic [TIME_BITS-1:0] half;
  logic [TIME_BITS-1:0] dh;
  logic [TIME_BITS-1:0] dw;
  logic                 hold_ok;
  logic                 win_ok;
  logic                 fire;

  // effective counts saturate at the ring depth
  always_comb begin
    if (32'(event_count) > 32'(MAX_EVENTS)) begin
      count_eff = CNT_W'(MAX_EVENTS);
    end else begin
      count_eff = CNT_W'(event_count);
    end
    if (32'(cfg_data[ebwa_pkg::COUNT_W-1:0]) > 32'(MAX_EVENTS)) begin
      count_new_eff = CNT_W'(MAX_EVENTS);
    end else begin
      count_new_eff = CNT_W'(cfg_data[ebwa_pkg::COUNT_W-1:0]);
    end
  end

  assign count_change = cfg_write && (cfg_index == ebwa_pkg::REG_EVENT_COUNT)
                        && (count_new_eff != count_eff);

  always_comb begin
    enabled = (count_eff != '0);
    if (32'(write_index) >= 32'(count_eff)) begin
      idx = '0;
    end else begin
      idx = write_index;
    end
    idx_inc = {1'b0, idx} + (IDX_W+1)'(1);
    if (32'(idx_inc) >= 32'(count_eff)) begin
      nxt = '0;
    end else begin
      nxt = idx_inc[IDX_W-1:0];
    end
  end

  assign out_free = !out_valid || alarms.ready;
  assign in_ready = !s1_valid || out_free;
  assign accept   = events.valid && in_ready;
  assign s1_move  = s1_valid && out_free;

  assign events.ready      = in_ready;
  assign alarms.valid      = out_valid;
  assign alarms.alarm      = out_alarm;
  assign alarms.oldest_time = out_oldest;

  ebwa_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (MAX_EVENTS),
    .ADDR_W(IDX_W)
  ) u_ring (
    .clk  (clk),
    .we   (accept && enabled),
    .waddr(idx),
    .wdata(events.event_time),
    .re   (accept),
    .raddr(nxt),
    .rdata(ring_rdata)
  );

  // decision stage
  always_comb begin
    if (s1_same) begin
      oldest = s1_now;
    end else if (s1_vld) begin
      oldest = ring_rdata;
    end else begin
      oldest = '0;
    end
    half    = time_threshold >> 1;
    dh      = s1_now - last_alarm_time;
    dw      = s1_now - oldest;
    hold_ok = !dh[TIME_BITS-1] && (dh > half);
    win_ok  = dw[TIME_BITS-1] || (dw <= time_threshold);
    fire    = s1_en && hold_ok && win_ok;
  end

  // configuration and ring bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      event_count    <= ebwa_pkg::EVENT_COUNT_RESET;
      time_threshold <= TIME_BITS'(ebwa_pkg::TIME_THRESHOLD_RESET);
      write_index    <= '0;
      ring_vld       <= '0;
    end else begin
      if (cfg_write && (cfg_index == ebwa_pkg::REG_EVENT_COUNT)) begin
        event_count <= cfg_data[ebwa_pkg::COUNT_W-1:0];
      end
      if (cfg_write && (cfg_index == ebwa_pkg::REG_TIME_THRESHOLD)) begin
        time_threshold <= cfg_data;
      end
      if (count_change) begin
        write_index <= '0;
        ring_vld    <= '0;
      end else if (accept && enabled) begin
        write_index   <= nxt;
        ring_vld[idx] <= 1'b1;
      end
    end
  end

  // ring read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_now  <= events.event_time;
      s1_en   <= enabled;
      s1_same <= (nxt == idx);
      s1_vld  <= ring_vld[nxt];
    end
  end

  // result register and holdoff time
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      last_alarm_time <= '0;
    end else begin
      if (s1_move) begin
        out_valid <= 1'b1;
        if (fire) begin
          last_alarm_time <= s1_now;
        end
      end else if (alarms.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_alarm  <= fire;
      out_oldest <= fire ? oldest : '0;
    end
  end

  // index stays inside the active ring
  assert property (@(posedge clk) disable iff (rst)
    (accept && enabled && !cfg_write) |=> (32'(write_index) < 32'(count_eff)))
    else $error("write index outside active ring");

  // disabled events report nothing and leave the holdoff time alone
  assert property (@(posedge clk) disable iff (rst)
    (s1_move && !s1_en) |=>
      (alarms.valid && !alarms.alarm && (last_alarm_time == $past(last_alarm_time))))
    else $error("disabled event changed state or raised alarm");

  // a raised alarm always records its event time
  assert property (@(posedge clk) disable iff (rst)
    (s1_move && fire) |=> (alarms.alarm && (last_alarm_time == $past(s1_now))))
    else $error("alarm without holdoff update");

endmodule

[tb/tb_event_burst_window_alarm_top.sv]
// self-checking testbench for the sliding window event rate alarm
`timescale 1ns / 100ps

module tb_event_burst_window_alarm_top;

  localparam int TW = ebwa_pkg::TIME_BITS_DEFAULT;
  localparam int MAXE = ebwa_pkg::MAX_EVENTS_DEFAULT;
  localparam int CW = ebwa_pkg::COUNT_W;
  localparam int AW = ebwa_pkg::CFG_ADDR_W;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 80;
  localparam logic [TW-1:0] TIME_MAX = {TW{1'b1}};
  localparam logic [TW-1:0] THR_RESET = TW'(ebwa_pkg::TIME_THRESHOLD_RESET);
  localparam logic [AW-1:0] REG_COUNT = ebwa_pkg::REG_EVENT_COUNT;
  localparam logic [AW-1:0] REG_THR = ebwa_pkg::REG_TIME_THRESHOLD;
  localparam logic [AW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [AW-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_t;

  typedef struct packed {
    logic          alarm;
    logic [TW-1:0] oldest;
  } alarm_result_t;

  typedef struct packed {
    logic          typed;
    alarm_result_t result;
  } pinned_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [AW-1:0]           reg_index;
    logic [TW-1:0]           value;
    logic                    typed;
    logic                    alarm;
    logic [TW-1:0]           oldest;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [AW-1:0] cfg_index;
  logic [TW-1:0] cfg_data;

  ebwa_event_if #(.TIME_BITS(TW)) events_ch ();
  ebwa_alarm_if #(.TIME_BITS(TW)) alarms_ch ();

  event_burst_window_alarm_top #(
    .MAX_EVENTS(MAXE),
    .TIME_BITS (TW)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .events   (events_ch),
    .alarms   (alarms_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // mirror of the window state
  logic [TW-1:0] win_ring [MAXE];
  int unsigned win_wr_idx;
  logic [TW-1:0] last_alarm_at;
  logic [CW-1:0] cnt_reg;
  logic [TW-1:0] thr_reg;

  alarm_result_t expected_alarms [$];
  pinned_t pinned_results [$];
  stim_row_t directed_rows [$];

  int fail_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit long_hold_done = 0;
  bit calm_phase = 0;

  always #5 clk = ~clk;

  function automatic int unsigned eff_count(input logic [CW-1:0] raw);
    return (32'(raw) > MAXE) ? MAXE : 32'(raw);
  endfunction

  function alarm_result_t step_window(input logic [TW-1:0] now);
    alarm_result_t r;
    int unsigned n, idx, nxt;
    logic [TW-1:0] half, dh, dw, oldest;
    r = '0;
    n = eff_count(cnt_reg);
    if (n == 0) return r;
    idx = win_wr_idx;
    if (idx >= n) idx = 0;
    win_ring[idx] = now;
    nxt = idx + 1;
    if (nxt >= n) nxt = 0;
    half = thr_reg >> 1;
    dh = now - last_alarm_at;
    if (!dh[TW-1] && dh > half) begin
      oldest = win_ring[nxt];
      dw = now - oldest;
      if (dw[TW-1] || dw <= thr_reg) begin
        r.alarm = 1'b1;
        r.oldest = oldest;
        last_alarm_at = now;
      end
    end
    win_wr_idx = nxt;
    return r;
  endfunction

  function automatic logic [TW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TW-1:0];
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic add_event(input logic [TW-1:0] t, input logic typed, input logic a,
                           input logic [TW-1:0] o);
    stim_row_t row;
    row = '0;
    row.kind = ROW_EVENT;
    row.value = t;
    row.typed = typed;
    row.alarm = a;
    row.oldest = o;
    directed_rows.push_back(row);
  endtask

  task automatic add_reg(input logic [AW-1:0] idx, input logic [TW-1:0] data);
    stim_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_index = idx;
    row.value = data;
    directed_rows.push_back(row);
  endtask

  task automatic send_event(input logic [TW-1:0] t, input logic typed, input logic a,
                            input logic [TW-1:0] o);
    pinned_t pin;
    int g;
    pin.typed = typed;
    pin.result.alarm = a;
    pin.result.oldest = o;
    pinned_results.push_back(pin);
    events_ch.valid <= 1'b1;
    events_ch.event_time <= t;
    do @(posedge clk); while (!events_ch.ready);
    if (eff_count(cnt_reg) != 0) items_sent++;
    g = pick_gap();
    if (g > 0) begin
      events_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    events_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_alarms.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic reg_write(input logic [AW-1:0] idx, input logic [TW-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input logic [TW-1:0] want,
                               input logic [TW-1:0] got);
    $error("%s: expected %0h, got %0h", field, want, got);
    fail_count++;
  endtask

  // request monitor: register writes and accepted events update the mirror
  always @(posedge clk) begin : req_monitor
    pinned_t pin;
    alarm_result_t res;
    logic [CW-1:0] nv;
    if (rst) begin
      foreach (win_ring[j]) win_ring[j] = '0;
      win_wr_idx = 0;
      last_alarm_at = '0;
      cnt_reg = ebwa_pkg::EVENT_COUNT_RESET;
      thr_reg = THR_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_COUNT) begin
          nv = cfg_data[CW-1:0];
          if (eff_count(nv) != eff_count(cnt_reg)) begin
            foreach (win_ring[j]) win_ring[j] = '0;
            win_wr_idx = 0;
          end
          cnt_reg = nv;
        end else if (cfg_index == REG_THR) begin
          thr_reg = cfg_data;
        end
      end
      if (events_ch.valid && events_ch.ready) begin
        pin = pinned_results.pop_front();
        res = step_window(events_ch.event_time);
        if (pin.typed) res = pin.result;
        expected_alarms.push_back(res);
      end
    end
  end

  // result checker and receiver stalls
  always @(posedge clk) begin : result_check
    alarm_result_t want;
    int r;
    if (!rst && alarms_ch.valid && alarms_ch.ready) begin
      if (expected_alarms.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        want = expected_alarms.pop_front();
        if (alarms_ch.alarm !== want.alarm)
          note_mismatch("alarm", TW'(want.alarm), TW'(alarms_ch.alarm));
        if (alarms_ch.oldest_time !== want.oldest)
          note_mismatch("oldest_time", want.oldest, alarms_ch.oldest_time);
      end
      results_seen++;
    end
    if (!long_hold_done && results_seen >= 300 && events_ch.valid) begin
      long_hold_done = 1;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      alarms_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      alarms_ch.ready <= 1'b0;
    end else begin
      alarms_ch.ready <= 1'b1;
      if (!calm_phase) begin
        r = $urandom_range(0, 99);
        if (r >= 97) stall_left = $urandom_range(8, 25);
        else if (r >= 70) stall_left = $urandom_range(1, 3);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    int burst, n, pick;
    logic [TW-1:0] t, hi, thr;
    logic [CW-1:0] c;
    logic [63:0] span, step;
    bit noisy;

    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    events_ch.valid = 1'b0;
    events_ch.event_time = '0;
    alarms_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset state: all ring entries zero, last alarm at zero
    add_event(48'd0, 1, 1'b0, 48'd0);
    add_event(48'd200000000, 1, 1'b1, 48'd0);
    add_event(TIME_MAX, 1, 1'b0, 48'd0);
    add_event(48'h7FFF_FFFF_FFFF, 0, 1'b0, 48'd0);
    add_event(48'd1, 0, 1'b0, 48'd0);
    // disabled
    add_reg(REG_COUNT, 48'd0);
    add_event(TIME_MAX, 1, 1'b0, 48'd0);
    add_event(48'd0, 1, 1'b0, 48'd0);
    // single entry window
    add_reg(REG_COUNT, 48'd1);
    add_event(48'd400000000, 0, 1'b0, 48'd0);
    add_event(48'd400000000, 0, 1'b0, 48'd0);
    add_event(48'd550000001, 0, 1'b0, 48'd0);
    add_reg(REG_THR, 48'd0);
    add_event(48'd600000000, 0, 1'b0, 48'd0);
    add_event(48'd600000000, 0, 1'b0, 48'd0);
    add_event(48'd600000001, 0, 1'b0, 48'd0);
    add_reg(REG_THR, TIME_MAX);
    add_event(TIME_MAX, 0, 1'b0, 48'd0);
    add_event(48'd0, 0, 1'b0, 48'd0);
    // unused register indexes are ignored
    add_reg(REG_SPARE_A, TIME_MAX);
    add_reg(REG_SPARE_B, 48'd0);
    // saturated count, then the same effective count again
    add_reg(REG_COUNT, 48'd31);
    add_reg(REG_THR, 48'd100);
    add_event(48'd1000, 0, 1'b0, 48'd0);
    add_reg(REG_COUNT, 48'd16);
    add_event(48'd1010, 0, 1'b0, 48'd0);
    add_event(48'd1020, 0, 1'b0, 48'd0);
    add_reg(REG_COUNT, 48'd2);
    add_event(48'd5000, 0, 1'b0, 48'd0);
    add_event(48'd5040, 0, 1'b0, 48'd0);
    add_event(48'd5080, 0, 1'b0, 48'd0);
    add_event(48'd5300, 0, 1'b0, 48'd0);
    add_event(48'd5050, 0, 1'b0, 48'd0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        reg_write(row.reg_index, row.value);
      end else begin
        send_event(row.value, row.typed, row.alarm, row.oldest);
      end
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      drain_results();
      calm_phase = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 7))
          0: c = 5'd0;
          1: c = 5'd1;
          2: c = 5'd16;
          3: c = CW'($urandom_range(17, 31));
          default: c = CW'($urandom_range(1, 16));
        endcase
        hi = rand_time();
        reg_write(REG_COUNT, {hi[TW-1:CW], c});
      end
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: thr = '0;
          1: thr = TIME_MAX;
          2: thr = THR_RESET;
          3: thr = rand_time();
          default: thr = TW'($urandom_range(0, 4000));
        endcase
        reg_write(REG_THR, thr);
      end
      if ($urandom_range(0, 9) == 0)
        reg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, rand_time());

      n = eff_count(cnt_reg);
      if (n == 0) n = 1;
      span = ({16'd0, thr_reg} * 64'd2) / n + 64'd2;
      burst = $urandom_range(20, 80);
      noisy = ($urandom_range(0, 4) == 0);
      t = $urandom_range(0, 1) ? rand_time() : TW'($urandom_range(0, 1000));
      for (int k = 0; k < burst; k++) begin
        pick = $urandom_range(0, 19);
        if (noisy || pick == 0) begin
          if ($urandom_range(0, 1)) t = rand_time();
          else t = t - TW'($urandom_range(0, 500));
        end else begin
          step = {$urandom(), $urandom()} % span;
          t = t + step[TW-1:0];
        end
        send_event(t, 0, 1'b0, '0);
      end
    end

    calm_phase = 0;
    drain_results();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[event_burst_window_alarm_top.f]
hw/rtl/ebwa_pkg.sv
hw/rtl/ebwa_event_if.sv
hw/rtl/ebwa_alarm_if.sv
hw/rtl/ebwa_ram.sv
hw/rtl/event_burst_window_alarm_top.sv
tb/tb_event_burst_window_alarm_top.sv
